### src/ptst_pkg.sv
// Package: shared types and constants for the periodic timer slot table.
`timescale 1ns / 1ps
package ptst_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam logic [15:0] TicksPerMsReset = 16'd100;
  localparam int unsigned MsWidth = 48;

  // operation codes
  localparam logic [1:0] OpTick     = 2'd0;
  localparam logic [1:0] OpRegister = 2'd1;
  localparam logic [1:0] OpClearMs  = 2'd2;
  localparam logic [1:0] OpAnswer   = 2'd3;

  // result kinds
  localparam logic [2:0] KindDone     = 3'd0;
  localparam logic [2:0] KindFired    = 3'd1;
  localparam logic [2:0] KindRegister = 3'd2;
  localparam logic [2:0] KindRejected = 3'd3;
  localparam logic [2:0] KindFull     = 3'd4;

  typedef struct packed {
    logic        used;
    logic        pending;
    logic [31:0] period;
    logic [31:0] elapsed;
    logic [7:0]  handler;
    logic [15:0] tag;
  } slot_rec_t;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFinal
  } state_e;

endpackage

### src/ptst_cell.sv
// One slot cell of the timer ring: holds a slot record, shifts or loads.
`timescale 1ns / 1ps
module ptst_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  ptst_pkg::slot_rec_t shift_rec_i,
  input  logic              wr_i,
  input  ptst_pkg::slot_rec_t wr_rec_i,
  output ptst_pkg::slot_rec_t rec_o
);

  ptst_pkg::slot_rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (shift_i) begin
      rec_d = shift_rec_i;
    end else if (wr_i) begin
      rec_d = wr_rec_i;
    end
  end

  // whole record cleared on reset: slot free, not pending
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

### src/periodic_timer_slot_table_top.sv
// Top level: prescaler, counters, control sequencer and the ring of slot cells.
// Register, clear and answer items and ticks that give no millisecond step each give
// one registered result; a millisecond step rotates the ring once past the head, one
// slot per cycle while the result side is free, and then sends the closing item.
// Throughput: one item at a time; back-pressure on the result side stalls the ring.
// Reset (async, active low): counters zero, all slots free, ticks_per_ms 100.
`timescale 1ns / 1ps
module periodic_timer_slot_table_top #(
  parameter int unsigned SLOTS = ptst_pkg::SlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,   // ticks_per_ms
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,    // operation
  // [0] interval_event, [32:1] interval_ms, [40:33] handler_id,
  // [56:41] user_tag, [60:57] answer_slot, [61] keep, [63:62] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [2:0]  m_axis_tuser,    // result_kind
  // [3:0] slot, [11:4] fired_handler, [27:12] fired_tag,
  // [75:28] ms_count, [83:76] error_count, [87:84] zero
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MW = ptst_pkg::MsWidth;

  // input fields
  logic [1:0]  in_op;
  logic        in_ev;
  logic [31:0] in_ivl;
  logic [7:0]  in_hid;
  logic [15:0] in_tag;
  logic [3:0]  in_asl;
  logic        in_keep;

  assign in_op   = s_axis_tuser;
  assign in_ev   = s_axis_tdata[0];
  assign in_ivl  = s_axis_tdata[32:1];
  assign in_hid  = s_axis_tdata[40:33];
  assign in_tag  = s_axis_tdata[56:41];
  assign in_asl  = s_axis_tdata[60:57];
  assign in_keep = s_axis_tdata[61];

  // state
  ptst_pkg::state_e state_q, state_d;
  logic [15:0]   tpm_q;
  logic [15:0]   sub_q, sub_d;
  logic [MW-1:0] ms_q, ms_d;
  logic [7:0]    err_q, err_d;
  logic [IW-1:0] idx_q, idx_d;

  // result register
  logic          ov_q, ov_d;
  logic [2:0]    okind_q, okind_d;
  logic [3:0]    oslot_q, oslot_d;
  logic [7:0]    ohid_q, ohid_d;
  logic [15:0]   otag_q, otag_d;
  logic          olast_q, olast_d;

  // ring
  ptst_pkg::slot_rec_t rec [SLOTS];
  ptst_pkg::slot_rec_t tail_rec;
  ptst_pkg::slot_rec_t wr_rec;
  logic [SLOTS-1:0]    wr_sel;
  logic                shift;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ptst_pkg::slot_rec_t nb;
    if (k == SLOTS - 1) begin : g_tail
      assign nb = tail_rec;
    end else begin : g_mid
      assign nb = rec[k+1];
    end
    ptst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .shift_rec_i (nb),
      .wr_i        (wr_sel[k]),
      .wr_rec_i    (wr_rec),
      .rec_o       (rec[k])
    );
  end

  // lowest free slot
  logic          free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!rec[k].used) begin
        free_found = 1'b1;
        free_idx   = IW'(k);
      end
    end
  end

  // answer target
  logic [6:0]    asl_ext;
  logic          asl_ok;
  logic [IW-1:0] asl_idx;
  assign asl_ext = {3'b000, in_asl};
  assign asl_ok  = asl_ext < 7'(SLOTS);
  assign asl_idx = IW'(asl_ext);

  // head update during the walk
  ptst_pkg::slot_rec_t head;
  logic [31:0] head_el;
  logic        head_fire;
  assign head    = rec[0];
  assign head_el = head.elapsed + 32'd1;
  always_comb begin
    tail_rec  = head;
    head_fire = 1'b0;
    if (head.used && !head.pending) begin
      tail_rec.elapsed = head_el;
      if (head_el >= head.period) begin
        tail_rec.pending = 1'b1;
        head_fire        = 1'b1;
      end
    end
  end

  logic       out_free;
  logic       accept;
  logic [6:0] idx_wide;
  logic [15:0] sub_inc;
  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ptst_pkg::StIdle) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_wide      = 7'(idx_q);
  assign sub_inc       = sub_q + 16'd1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptst_pkg::StIdle: begin
        if (accept && in_op == ptst_pkg::OpTick && in_ev && sub_inc >= tpm_q) begin
          state_d = ptst_pkg::StWalk;
        end
      end
      ptst_pkg::StWalk: begin
        if (out_free && idx_q == IW'(SLOTS - 1)) begin
          state_d = ptst_pkg::StFinal;
        end
      end
      ptst_pkg::StFinal: begin
        if (out_free) begin
          state_d = ptst_pkg::StIdle;
        end
      end
      default: state_d = ptst_pkg::StIdle;
    endcase
  end

  // datapath and results
  always_comb begin
    sub_d   = sub_q;
    ms_d    = ms_q;
    err_d   = err_q;
    idx_d   = idx_q;
    shift   = 1'b0;
    wr_sel  = '0;
    wr_rec  = rec[asl_idx];
    ov_d    = ov_q && !m_axis_tready;
    okind_d = okind_q;
    oslot_d = oslot_q;
    ohid_d  = ohid_q;
    otag_d  = otag_q;
    olast_d = olast_q;
    unique case (state_q)
      ptst_pkg::StIdle: begin
        idx_d = '0;
        if (accept) begin
          ov_d    = 1'b1;
          okind_d = ptst_pkg::KindDone;
          oslot_d = '0;
          ohid_d  = '0;
          otag_d  = '0;
          olast_d = 1'b1;
          case (in_op)
            ptst_pkg::OpTick: begin
              if (!in_ev) begin
                err_d = err_q + 8'd1;
              end else if (sub_inc >= tpm_q) begin
                sub_d = '0;
                ms_d  = ms_q + MW'(1);
                ov_d  = 1'b0;
              end else begin
                sub_d = sub_inc;
              end
            end
            ptst_pkg::OpRegister: begin
              if (in_hid == 8'd0 || in_ivl == 32'd0) begin
                okind_d = ptst_pkg::KindRejected;
              end else if (!free_found) begin
                okind_d = ptst_pkg::KindFull;
              end else begin
                wr_rec.used     = 1'b1;
                wr_rec.pending  = 1'b0;
                wr_rec.period   = in_ivl;
                wr_rec.elapsed  = '0;
                wr_rec.handler  = in_hid;
                wr_rec.tag      = in_tag;
                wr_sel[free_idx] = 1'b1;
                okind_d = ptst_pkg::KindRegister;
                oslot_d = 4'(7'(free_idx));
              end
            end
            ptst_pkg::OpClearMs: begin
              ms_d = '0;
            end
            ptst_pkg::OpAnswer: begin
              if (!asl_ok || !rec[asl_idx].pending) begin
                okind_d = ptst_pkg::KindRejected;
              end else begin
                wr_rec.pending = 1'b0;
                if (in_keep) begin
                  wr_rec.elapsed = '0;
                end else begin
                  wr_rec.used = 1'b0;
                end
                wr_sel[asl_idx] = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ptst_pkg::StWalk: begin
        if (out_free) begin
          shift = 1'b1;
          idx_d = idx_q + IW'(1);
          if (head_fire) begin
            ov_d    = 1'b1;
            okind_d = ptst_pkg::KindFired;
            oslot_d = idx_wide[3:0];
            ohid_d  = head.handler;
            otag_d  = head.tag;
            olast_d = 1'b0;
          end
        end
      end
      ptst_pkg::StFinal: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = ptst_pkg::KindDone;
          oslot_d = '0;
          ohid_d  = '0;
          otag_d  = '0;
          olast_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptst_pkg::StIdle;
      tpm_q   <= ptst_pkg::TicksPerMsReset;
      sub_q   <= '0;
      ms_q    <= '0;
      err_q   <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        tpm_q <= cfg_wr_data_i;
      end
      sub_q <= sub_d;
      ms_q  <= ms_d;
      err_q <= err_d;
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oslot_q <= oslot_d;
    ohid_q  <= ohid_d;
    otag_q  <= otag_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {4'b0000, err_q, ms_q, otag_q, ohid_q, oslot_q};

endmodule

### verif/periodic_timer_slot_table_top_tb.sv
// Testbench: periodic timer slot table driven by item streams, checked against a local predictor.
`timescale 1ns / 1ps
module periodic_timer_slot_table_top_tb;

  localparam int unsigned NSlots = 16;
  localparam int unsigned CycleLimit = 400000;

  // One input item as it travels on the slave side
  typedef struct packed {
    logic [1:0]  op;
    logic        ev;
    logic [31:0] ivl;
    logic [7:0]  hid;
    logic [15:0] tag;
    logic [3:0]  asl;
    logic        kp;
  } timer_req_t;

  // One result item as it arrives on the master side
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [7:0]  handler;
    logic [15:0] tag;
    logic [47:0] ms;
    logic [7:0]  errs;
    logic        last;
  } timer_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [15:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [2:0]  m_axis_tuser;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;

  periodic_timer_slot_table_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_wr_en_i(cfg_wr_en_i), .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state: a private copy of the prescaler, counters and slot table
  logic [15:0] pred_ticks_per_ms;
  logic [15:0] pred_sub_tick;
  logic [47:0] pred_millis;
  logic [7:0]  pred_errors;
  logic        pred_used    [NSlots];
  logic        pred_pending [NSlots];
  logic [31:0] pred_period  [NSlots];
  logic [31:0] pred_elapsed [NSlots];
  logic [7:0]  pred_handler [NSlots];
  logic [15:0] pred_tag     [NSlots];

  timer_req_t pending_reqs[$];   // filled by stimulus, drained by the driver
  timer_res_t expected_res[$];   // predicted results, oldest first
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned results_seen = 0;
  bit calm = 1'b0;        // final stretch: no idling on either side
  bit hold_sink = 1'b0;   // long receiver hold-off requested
  bit timed_out = 1'b0;

  task automatic report_mismatch(input string what, input timer_res_t got,
                                 input timer_res_t want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  function automatic timer_res_t mk_res(input logic [2:0] kind, input logic [3:0] slot,
                                        input logic [7:0] h, input logic [15:0] t,
                                        input logic last);
    timer_res_t r;
    r.kind = kind; r.slot = slot; r.handler = h; r.tag = t;
    r.ms = pred_millis; r.errs = pred_errors; r.last = last;
    return r;
  endfunction

  function automatic logic [63:0] pack_req(input timer_req_t q);
    return {2'b00, q.kp, q.asl, q.tag, q.hid, q.ivl, q.ev};
  endfunction

  // Work out the results of one accepted item and queue them
  task automatic predict_timer_item(input timer_req_t q);
    int i;
    bit placed;
    if (q.op == ptst_pkg::OpTick) begin
      if (!q.ev) begin
        pred_errors = pred_errors + 8'd1;
      end else begin
        pred_sub_tick = pred_sub_tick + 16'd1;
        if (pred_sub_tick >= pred_ticks_per_ms) begin
          pred_sub_tick = '0;
          pred_millis = pred_millis + 48'd1;
          for (i = 0; i < NSlots; i++) begin
            if (pred_used[i] && !pred_pending[i]) begin
              pred_elapsed[i] = pred_elapsed[i] + 32'd1;
              if (pred_elapsed[i] >= pred_period[i]) begin
                pred_pending[i] = 1'b1;
                expected_res.push_back(mk_res(ptst_pkg::KindFired, 4'(i), pred_handler[i],
                                              pred_tag[i], 1'b0));
              end
            end
          end
        end
      end
      expected_res.push_back(mk_res(ptst_pkg::KindDone, '0, '0, '0, 1'b1));
    end else if (q.op == ptst_pkg::OpRegister) begin
      if (q.hid == 0 || q.ivl == 0) begin
        expected_res.push_back(mk_res(ptst_pkg::KindRejected, '0, '0, '0, 1'b1));
      end else begin
        placed = 1'b0;
        for (i = 0; i < NSlots; i++) begin
          if (!placed && !pred_used[i]) begin
            placed = 1'b1;
            pred_used[i] = 1'b1; pred_pending[i] = 1'b0;
            pred_period[i] = q.ivl; pred_elapsed[i] = '0;
            pred_handler[i] = q.hid; pred_tag[i] = q.tag;
            expected_res.push_back(mk_res(ptst_pkg::KindRegister, 4'(i), '0, '0, 1'b1));
          end
        end
        if (!placed) expected_res.push_back(mk_res(ptst_pkg::KindFull, '0, '0, '0, 1'b1));
      end
    end else if (q.op == ptst_pkg::OpClearMs) begin
      pred_millis = '0;
      expected_res.push_back(mk_res(ptst_pkg::KindDone, '0, '0, '0, 1'b1));
    end else begin
      if (!pred_pending[q.asl]) begin
        expected_res.push_back(mk_res(ptst_pkg::KindRejected, '0, '0, '0, 1'b1));
      end else begin
        pred_pending[q.asl] = 1'b0;
        if (q.kp) pred_elapsed[q.asl] = '0;
        else pred_used[q.asl] = 1'b0;
        expected_res.push_back(mk_res(ptst_pkg::KindDone, '0, '0, '0, 1'b1));
      end
    end
  endtask

  // Sender: idles in random bursts until the final stretch
  int unsigned src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_timer_item(pending_reqs.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(1, 15);
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        // the queue head is the offered item until it is accepted
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_reqs[0].op;
        s_axis_tdata <= pack_req(pending_reqs[0]);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off on request
  int unsigned sink_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin : b_check
        timer_res_t g;
        timer_res_t w;
        results_seen++;
        g.kind    = m_axis_tuser;
        g.slot    = m_axis_tdata[3:0];
        g.handler = m_axis_tdata[11:4];
        g.tag     = m_axis_tdata[27:12];
        g.ms      = m_axis_tdata[75:28];
        g.errs    = m_axis_tdata[83:76];
        g.last    = m_axis_tlast;
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result", g, '0);
        end else begin
          w = expected_res.pop_front();
          if (g !== w) report_mismatch("result", g, w);
        end
      end
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_gap <= $urandom_range(1, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit && !timed_out) begin
      timed_out <= 1'b1;
      $display("FAIL periodic_timer_slot_table_top");
      $finish;
    end
  end

  // Long receiver hold-off, counted in its own process
  initial begin
    int n;
    wait (results_seen > 40);
    hold_sink = 1'b1;
    for (n = 0; n < 300; n++) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  task automatic add_req(input logic [1:0] op, input logic ev, input logic [31:0] ivl,
                         input logic [7:0] hid, input logic [15:0] tag,
                         input logic [3:0] asl, input logic kp);
    timer_req_t q;
    q.op = op; q.ev = ev; q.ivl = ivl; q.hid = hid; q.tag = tag; q.asl = asl; q.kp = kp;
    pending_reqs.push_back(q);
  endtask

  // Random content in unused fields so every bit toggles
  task automatic add_rand(input logic [1:0] op, input logic ev, input logic [31:0] ivl,
                          input logic [7:0] hid, input logic [3:0] asl, input logic kp);
    add_req(op, ev, ivl, hid, 16'($urandom), asl, kp);
  endtask

  // Let everything drain, then allow for a millisecond walk still in flight
  task automatic drain();
    int n;
    wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_res.size() == 0);
    for (n = 0; n < 3 * NSlots; n++) @(posedge clk_i);
  endtask

  task automatic write_prescaler(input logic [15:0] v);
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    pred_ticks_per_ms = v;
  endtask

  task automatic random_phase(input int count, input int max_period);
    int k;
    int sel;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) add_rand(ptst_pkg::OpTick, 1'($urandom_range(0, 9) != 0), $urandom,
                             8'($urandom), 4'($urandom), 1'($urandom));
      else if (sel < 72) add_rand(ptst_pkg::OpRegister, 1'($urandom),
                                  ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                              : 32'($urandom_range(0, max_period)),
                                  ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom),
                                  4'($urandom), 1'($urandom));
      else if (sel < 77) add_rand(ptst_pkg::OpClearMs, 1'($urandom), $urandom, 8'($urandom),
                                  4'($urandom), 1'($urandom));
      else add_rand(ptst_pkg::OpAnswer, 1'($urandom), $urandom, 8'($urandom), 4'($urandom),
                    1'($urandom_range(0, 3) != 0));
    end
  endtask

  initial begin
    int i;
    pred_ticks_per_ms = ptst_pkg::TicksPerMsReset;
    pred_sub_tick = '0; pred_millis = '0; pred_errors = '0;
    for (i = 0; i < NSlots; i++) begin
      pred_used[i] = 1'b0; pred_pending[i] = 1'b0; pred_period[i] = '0;
      pred_elapsed[i] = '0; pred_handler[i] = '0; pred_tag[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: rejects, extremes, stray answers, then one ms per tick
    add_req(ptst_pkg::OpRegister, 1'b0, 32'd0, 8'hFF, 16'hFFFF, 4'hF, 1'b1);
    add_req(ptst_pkg::OpRegister, 1'b1, 32'hFFFF_FFFF, 8'd0, 16'h0, 4'h0, 1'b0);
    add_req(ptst_pkg::OpRegister, 1'b1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 4'h0, 1'b0);
    add_req(ptst_pkg::OpRegister, 1'b0, 32'd1, 8'd1, 16'h0000, 4'hF, 1'b1);
    add_req(ptst_pkg::OpAnswer, 1'b1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 4'hF, 1'b1);
    add_req(ptst_pkg::OpTick, 1'b0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 4'hF, 1'b1);
    add_req(ptst_pkg::OpTick, 1'b1, 32'h0, 8'h0, 16'h0, 4'h0, 1'b0);
    add_req(ptst_pkg::OpClearMs, 1'b1, 32'h0, 8'h0, 16'h0, 4'h0, 1'b0);
    drain();
    write_prescaler(16'd0);   // zero acts as one
    add_req(ptst_pkg::OpTick, 1'b1, 32'h0, 8'h0, 16'h0, 4'h0, 1'b0);   // slot 1 fires
    add_req(ptst_pkg::OpAnswer, 1'b0, 32'h0, 8'h0, 16'h0, 4'd1, 1'b1); // keep
    add_req(ptst_pkg::OpTick, 1'b1, 32'h0, 8'h0, 16'h0, 4'h0, 1'b0);
    add_req(ptst_pkg::OpAnswer, 1'b0, 32'h0, 8'h0, 16'h0, 4'd1, 1'b0); // drop
    add_req(ptst_pkg::OpAnswer, 1'b0, 32'h0, 8'h0, 16'h0, 4'd1, 1'b0); // now stray
    for (i = 0; i < 16; i++) add_rand(ptst_pkg::OpRegister, 1'b1, 32'd1, 8'(i + 2), 4'h0, 1'b0);
    add_req(ptst_pkg::OpTick, 1'b1, 32'h0, 8'h0, 16'h0, 4'h0, 1'b0);   // every period-1 slot fires
    drain();

    // Random phases across prescaler settings, extremes among them
    write_prescaler(16'd1);
    random_phase(45, 4);
    drain();
    write_prescaler(16'd3);
    random_phase(40, 6);
    drain();
    write_prescaler(16'hFFFF);   // no step in practice: sub_tick well below
    random_phase(15, 6);
    drain();
    write_prescaler(16'd1);      // lowered: pending sub_tick steps at once
    calm = 1'b1;
    random_phase(30, 4);
    drain();

    if (mismatches == 0) begin
      $display("PASS periodic_timer_slot_table_top");
    end else begin
      $display("FAIL periodic_timer_slot_table_top");
    end
    $finish;
  end

endmodule
